### rtl/core/vms_pkg.sv
`timescale 1ns / 1ps
package vms_pkg;

   localparam int DATA_W    = 32;
   localparam int MU_W      = 31;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_LAME_LAMBDA   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHEAR_MODULUS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AXISYMMETRIC  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_RADIUS = 2'd2;

endpackage

### rtl/core/vms_req_if.sv
`timescale 1ns / 1ps
interface vms_req_if import vms_pkg::*; ;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] du_dx;
   logic signed [DATA_W-1:0] du_dy;
   logic signed [DATA_W-1:0] dv_dx;
   logic signed [DATA_W-1:0] dv_dy;
   logic signed [DATA_W-1:0] u_value;
   logic signed [DATA_W-1:0] radius;

   modport source (output valid, du_dx, du_dy, dv_dx, dv_dy, u_value, radius, input ready);
   modport sink   (input valid, du_dx, du_dy, dv_dx, dv_dy, u_value, radius, output ready);
endinterface

### rtl/core/vms_rsp_if.sv
`timescale 1ns / 1ps
interface vms_rsp_if import vms_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   stress;
   logic [STATUS_W-1:0] status;

   modport source (output valid, stress, status, input ready);
   modport sink   (input valid, stress, status, output ready);
endinterface

### rtl/core/vms_csr_if.sv
`timescale 1ns / 1ps
interface vms_csr_if import vms_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/von_mises_stress_point.sv
`timescale 1ns / 1ps
// von Mises equivalent stress of one quadrature point per transaction.
// req_ch carries the four displacement gradients, u_value and radius
// (signed fixed point, FRAC_BITS fraction bits). rsp_ch returns stress
// (unsigned fixed point, saturated) and status (ok, saturated, zero radius
// in axisymmetric mode). csr_ch writes lame_lambda, shear_modulus and
// axisymmetric; it is always ready and should be written while idle.
// From request to response there are 4 tensor stages, a radix-4
// hoop divider of 32 stages, 7 difference and squaring stages and a
// 32-stage bit-per-stage square root. One transaction is accepted every
// cycle unless rsp_ch stalls with a result waiting. The whole pipeline
// advances on one enable: in that case every stage holds, bubbles
// included, and req_ch.ready stays low until rsp_ch.ready returns.
// Reset (synchronous, active high) empties the pipeline and clears all
// three registers to zero.
module von_mises_stress_point import vms_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   vms_req_if.sink    req_ch,
   vms_rsp_if.source  rsp_ch,
   vms_csr_if.sink    csr_ch
);

   localparam int DIV_STEP    = 2;
   localparam int NUM_W       = 64;
   localparam int DEN_W       = 32;
   localparam int DIV_STAGES  = NUM_W / DIV_STEP;
   localparam int ROOT_W      = 32;
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int REM_W       = ROOT_W + 2;
   localparam int SQRT_STAGES = ROOT_W;
   localparam int MAG_W       = 60;
   localparam int HALF_W      = MAG_W / 2;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int SUM_W       = SQ_W + 4;
   localparam int NSTAGE      = 4 + DIV_STAGES + 3 + 4 + SQRT_STAGES;
   localparam logic [NUM_W-1:0] HOOP_MAX = 64'h0400_0000_0000_0000;

   typedef struct packed {
      logic signed [63:0] ld;
      logic signed [63:0] lv;
      logic signed [63:0] md;
      logic signed [63:0] mv;
      logic signed [63:0] mu;
      logic signed [63:0] mx;
   } prod_type;

   typedef struct packed {
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] c;
      logic signed [63:0] txy;
   } tens_type;

   typedef struct packed {
      logic neg;
      logic hoop;
      logic zero;
   } flag_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] num;
   } div_state_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } sq_state_type;

   function automatic div_state_type div_step(div_state_type st, logic [DEN_W-1:0] den);
      div_state_type r;
      logic [DEN_W:0] t;
      r = st;
      for (int i = 0; i < DIV_STEP; i++) begin
         t     = {r.rem, r.num[NUM_W-1]};
         r.num = {r.num[NUM_W-2:0], 1'b0};
         if (t >= {1'b0, den}) begin
            r.rem    = DEN_W'(t - {1'b0, den});
            r.num[0] = 1'b1;
         end else begin
            r.rem = t[DEN_W-1:0];
         end
      end
      return r;
   endfunction

   function automatic sq_state_type sqrt_step(sq_state_type st);
      sq_state_type r;
      logic [REM_W+1:0] acc;
      logic [REM_W+1:0] trial;
      r     = st;
      acc   = {r.rem, r.rad[RAD_W-1 -: 2]};
      trial = {2'b00, r.root, 2'b01};
      r.rad = {r.rad[RAD_W-3:0], 2'b00};
      if (acc >= trial) begin
         r.rem  = REM_W'(acc - trial);
         r.root = {r.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = acc[REM_W-1:0];
         r.root = {r.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [MAG_W-1:0] mag(logic signed [63:0] v);
      return v[63] ? MAG_W'(-v) : MAG_W'(v);
   endfunction

   // configuration
   logic signed [DATA_W-1:0] lambda_ff;
   logic [MU_W-1:0]          mu_ff;
   logic                     axi_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff <= '0;
         mu_ff     <= '0;
         axi_ff    <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_LAME_LAMBDA:   lambda_ff <= csr_ch.data;
            REG_SHEAR_MODULUS: mu_ff     <= csr_ch.data[MU_W-1:0];
            REG_AXISYMMETRIC:  axi_ff    <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [NSTAGE-1:0] vld_ff;
   logic              adv;

   assign adv          = !vld_ff[NSTAGE-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], req_ch.valid};
      end
   end

   // stage 1: products
   prod_type          s1_p_in, s1_p_ff;
   flag_type          s1_f_in, s1_f_ff, s2_f_ff, s3_f_ff, s4_f_ff;
   logic [NUM_W-1:0]  s1_num_in, s1_num_ff, s2_num_ff, s3_num_ff, s4_num_ff;
   logic [DEN_W-1:0]  s1_den_in, s1_den_ff, s2_den_ff, s3_den_ff, s4_den_ff;
   logic [DATA_W-1:0] u_mag;
   logic [62:0]       hoop_prod;
   logic signed [DATA_W-1:0] mu_s;

   always_comb begin
      mu_s       = signed'({1'b0, mu_ff});
      s1_p_in.ld = lambda_ff * req_ch.du_dx;
      s1_p_in.lv = lambda_ff * req_ch.dv_dy;
      s1_p_in.md = mu_s * req_ch.du_dx;
      s1_p_in.mv = mu_s * req_ch.dv_dy;
      s1_p_in.mu = mu_s * req_ch.du_dy;
      s1_p_in.mx = mu_s * req_ch.dv_dx;
      u_mag      = req_ch.u_value[DATA_W-1] ? DATA_W'(-req_ch.u_value) : req_ch.u_value;
      hoop_prod  = mu_ff * u_mag;
      s1_num_in  = {hoop_prod, 1'b0};
      s1_den_in  = req_ch.radius[DATA_W-1] ? DEN_W'(-req_ch.radius) : req_ch.radius;
      s1_f_in.neg  = req_ch.u_value[DATA_W-1] ^ req_ch.radius[DATA_W-1];
      s1_f_in.hoop = axi_ff;
      s1_f_in.zero = axi_ff && (req_ch.radius == '0);
   end

   // stages 2..4: tensor and differences
   tens_type s2_t_in, s2_t_ff, s3_t_in, s3_t_ff, s4_t_in, s4_t_ff;

   always_comb begin
      s2_t_in.a   = (s1_p_ff.ld >>> FRAC_BITS) + (s1_p_ff.lv >>> FRAC_BITS);
      s2_t_in.b   = (s1_p_ff.md >>> FRAC_BITS) <<< 1;
      s2_t_in.c   = (s1_p_ff.mv >>> FRAC_BITS) <<< 1;
      s2_t_in.txy = (s1_p_ff.mu >>> FRAC_BITS) + (s1_p_ff.mx >>> FRAC_BITS);
      // a: tz, b: tx, c: ty
      s3_t_in.a   = s2_t_ff.a;
      s3_t_in.b   = s2_t_ff.a + s2_t_ff.b;
      s3_t_in.c   = s2_t_ff.a + s2_t_ff.c;
      s3_t_in.txy = s2_t_ff.txy;
      // a: tx-ty, b: ty-tz, c: tz-tx
      s4_t_in.a   = s3_t_ff.b - s3_t_ff.c;
      s4_t_in.b   = s3_t_ff.c - s3_t_ff.a;
      s4_t_in.c   = s3_t_ff.a - s3_t_ff.b;
      s4_t_in.txy = s3_t_ff.txy;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_p_ff   <= s1_p_in;
         s1_f_ff   <= s1_f_in;
         s1_num_ff <= s1_num_in;
         s1_den_ff <= s1_den_in;
         s2_t_ff   <= s2_t_in;
         s2_f_ff   <= s1_f_ff;
         s2_num_ff <= s1_num_ff;
         s2_den_ff <= s1_den_ff;
         s3_t_ff   <= s3_t_in;
         s3_f_ff   <= s2_f_ff;
         s3_num_ff <= s2_num_ff;
         s3_den_ff <= s2_den_ff;
         s4_t_ff   <= s4_t_in;
         s4_f_ff   <= s3_f_ff;
         s4_num_ff <= s3_num_ff;
         s4_den_ff <= s3_den_ff;
      end
   end

   // hoop divider, two quotient bits per stage
   div_state_type    dv_st_in [DIV_STAGES];
   div_state_type    dv_st_ff [DIV_STAGES];
   logic [DEN_W-1:0] dv_den_ff [DIV_STAGES];
   tens_type         dv_t_ff [DIV_STAGES];
   flag_type         dv_f_ff [DIV_STAGES];
   div_state_type    dv_init;

   always_comb begin
      dv_init.rem = '0;
      dv_init.num = s4_num_ff;
      dv_st_in[0] = div_step(dv_init, s4_den_ff);
      for (int k = 1; k < DIV_STAGES; k++) begin
         dv_st_in[k] = div_step(dv_st_ff[k-1], dv_den_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_st_ff[0]  <= dv_st_in[0];
         dv_den_ff[0] <= s4_den_ff;
         dv_t_ff[0]   <= s4_t_ff;
         dv_f_ff[0]   <= s4_f_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            dv_st_ff[k]  <= dv_st_in[k];
            dv_den_ff[k] <= dv_den_ff[k-1];
            dv_t_ff[k]   <= dv_t_ff[k-1];
            dv_f_ff[k]   <= dv_f_ff[k-1];
         end
      end
   end

   // hoop term, differences, magnitudes
   logic [NUM_W-1:0]   quot, quot_lim;
   logic signed [63:0] p1_hs_in, p1_hs_ff;
   tens_type           p1_t_ff, p2_t_in, p2_t_ff;
   logic               p1_zero_ff, p2_zero_ff, p3_zero_ff;
   logic [3:0][MAG_W-1:0] p3_m_in, p3_m_ff;

   always_comb begin
      quot     = dv_st_ff[DIV_STAGES-1].num;
      quot_lim = (quot > HOOP_MAX) ? HOOP_MAX : quot;
      if (!dv_f_ff[DIV_STAGES-1].hoop) begin
         p1_hs_in = '0;
      end else if (dv_f_ff[DIV_STAGES-1].neg) begin
         p1_hs_in = -signed'(quot_lim);
      end else begin
         p1_hs_in = signed'(quot_lim);
      end
      p2_t_in.a   = p1_t_ff.a;
      p2_t_in.b   = p1_t_ff.b - p1_hs_ff;
      p2_t_in.c   = p1_t_ff.c + p1_hs_ff;
      p2_t_in.txy = p1_t_ff.txy;
      p3_m_in[0]  = mag(p2_t_ff.a);
      p3_m_in[1]  = mag(p2_t_ff.b);
      p3_m_in[2]  = mag(p2_t_ff.c);
      p3_m_in[3]  = mag(p2_t_ff.txy);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_hs_ff   <= p1_hs_in;
         p1_t_ff    <= dv_t_ff[DIV_STAGES-1];
         p1_zero_ff <= dv_f_ff[DIV_STAGES-1].zero;
         p2_t_ff    <= p2_t_in;
         p2_zero_ff <= p1_zero_ff;
         p3_m_ff    <= p3_m_in;
         p3_zero_ff <= p2_zero_ff;
      end
   end

   // squares and sum
   logic [3:0][MAG_W-1:0] m1_hh_in, m1_hl_in, m1_ll_in, m1_hh_ff, m1_hl_ff, m1_ll_ff;
   logic [3:0][SQ_W-1:0]  m2_sq_in, m2_sq_ff;
   logic [SUM_W-1:0]      m3_a_in, m3_b_in, m3_a_ff, m3_b_ff, sum;
   logic                  m1_zero_ff, m2_zero_ff, m3_zero_ff;
   logic [RAD_W-1:0]      m4_rad_ff;
   logic [STATUS_W-1:0]   m4_status_in, m4_status_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         m1_hh_in[j] = p3_m_ff[j][MAG_W-1:HALF_W] * p3_m_ff[j][MAG_W-1:HALF_W];
         m1_hl_in[j] = p3_m_ff[j][MAG_W-1:HALF_W] * p3_m_ff[j][HALF_W-1:0];
         m1_ll_in[j] = p3_m_ff[j][HALF_W-1:0] * p3_m_ff[j][HALF_W-1:0];
         m2_sq_in[j] = {m1_hh_ff[j], {MAG_W{1'b0}}}
                     + SQ_W'({m1_hl_ff[j], {(HALF_W+1){1'b0}}})
                     + SQ_W'(m1_ll_ff[j]);
      end
      m3_a_in = SUM_W'(m2_sq_ff[0]) + SUM_W'(m2_sq_ff[1]);
      m3_b_in = SUM_W'(m2_sq_ff[2]) + SUM_W'({m2_sq_ff[3], 2'b00})
              + SUM_W'({m2_sq_ff[3], 1'b0});
      sum     = m3_a_ff + m3_b_ff;
      if (m3_zero_ff) begin
         m4_status_in = STATUS_ZERO_RADIUS;
      end else if (|sum[SUM_W-1:RAD_W+1]) begin
         m4_status_in = STATUS_SATURATED;
      end else begin
         m4_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_hh_ff     <= m1_hh_in;
         m1_hl_ff     <= m1_hl_in;
         m1_ll_ff     <= m1_ll_in;
         m1_zero_ff   <= p3_zero_ff;
         m2_sq_ff     <= m2_sq_in;
         m2_zero_ff   <= m1_zero_ff;
         m3_a_ff      <= m3_a_in;
         m3_b_ff      <= m3_b_in;
         m3_zero_ff   <= m2_zero_ff;
         m4_rad_ff    <= sum[RAD_W:1];
         m4_status_ff <= m4_status_in;
      end
   end

   // square root, one result bit per stage
   sq_state_type        sr_st_in [SQRT_STAGES];
   sq_state_type        sr_st_ff [SQRT_STAGES];
   logic [STATUS_W-1:0] sr_status_ff [SQRT_STAGES];
   sq_state_type        sr_init;

   always_comb begin
      sr_init.rem  = '0;
      sr_init.root = '0;
      sr_init.rad  = m4_rad_ff;
      sr_st_in[0]  = sqrt_step(sr_init);
      for (int k = 1; k < SQRT_STAGES; k++) begin
         sr_st_in[k] = sqrt_step(sr_st_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sr_st_ff[0]     <= sr_st_in[0];
         sr_status_ff[0] <= m4_status_ff;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            sr_st_ff[k]     <= sr_st_in[k];
            sr_status_ff[k] <= sr_status_ff[k-1];
         end
      end
   end

   assign rsp_ch.valid  = vld_ff[NSTAGE-1];
   assign rsp_ch.status = sr_status_ff[SQRT_STAGES-1];
   assign rsp_ch.stress = (sr_status_ff[SQRT_STAGES-1] == STATUS_OK)
                        ? sr_st_ff[SQRT_STAGES-1].root : '1;

endmodule

### tb/von_mises_stress_point_checker.sv
`timescale 1ns / 1ps
module von_mises_stress_point_checker import vms_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic  clock,
   input  logic  reset,
   vms_req_if    req,
   vms_rsp_if    rsp,
   vms_csr_if    csr,
   output int    errors,
   output int    pending,
   output int    results_seen
);

   localparam int EXP_DEPTH = 256;

   typedef struct packed {
      logic [DATA_W-1:0]   stress;
      logic [STATUS_W-1:0] status;
   } stress_result_type;

   logic signed [DATA_W-1:0] lambda_q;
   logic [MU_W-1:0]          mu_q;
   logic                     axisym;
   stress_result_type        expected_mem [EXP_DEPTH];
   int                       exp_wr;
   int                       exp_rd;

   function automatic longint fx_mul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic stress_result_type predict_stress(longint dudx, longint dudy,
                                                        longint dvdx, longint dvdy,
                                                        longint uval, longint rad);
      stress_result_type r;
      longint            lam, mu, tz, tx, ty, txy;
      logic [63:0]       num, den, q, d, root;
      logic [127:0]      sum;
      lam = longint'(lambda_q);
      mu  = longint'({1'b0, mu_q});
      tz  = fx_mul(lam, dudx) + fx_mul(lam, dvdy);
      tx  = tz + 2 * fx_mul(mu, dudx);
      ty  = tz + 2 * fx_mul(mu, dvdy);
      txy = fx_mul(mu, dudy) + fx_mul(mu, dvdx);
      if (axisym) begin
         if (rad == 0) begin
            r.stress = '1;
            r.status = STATUS_ZERO_RADIUS;
            return r;
         end
         num = 64'd2 * {33'd0, mu_q} * magnitude(uval);
         den = magnitude(rad);
         q   = num / den;
         if (q > (64'd1 << 58)) q = 64'd1 << 58;
         if ((uval < 0) != (rad < 0)) tz = tz - longint'(q);
         else tz = tz + longint'(q);
      end
      d   = magnitude(tx - ty);
      sum = {64'd0, d} * {64'd0, d};
      d   = magnitude(ty - tz);
      sum = sum + {64'd0, d} * {64'd0, d};
      d   = magnitude(tz - tx);
      sum = sum + {64'd0, d} * {64'd0, d};
      d   = magnitude(txy);
      sum = sum + 128'd6 * {64'd0, d} * {64'd0, d};
      sum = sum >> 1;
      if (sum[127:64] != 0) begin
         r.stress = '1;
         r.status = STATUS_SATURATED;
      end else begin
         root     = int_sqrt(sum[63:0]);
         r.stress = root[DATA_W-1:0];
         r.status = STATUS_OK;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      stress_result_type e;
      if (reset) begin
         lambda_q     <= '0;
         mu_q         <= '0;
         axisym       <= 1'b0;
         exp_wr       <= 0;
         exp_rd       <= 0;
         errors       <= 0;
         results_seen <= 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_LAME_LAMBDA:   lambda_q <= csr.data;
               REG_SHEAR_MODULUS: mu_q     <= csr.data[MU_W-1:0];
               REG_AXISYMMETRIC:  axisym   <= csr.data[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            expected_mem[exp_wr % EXP_DEPTH] <= predict_stress(req.du_dx, req.du_dy,
                                                               req.dv_dx, req.dv_dy,
                                                               req.u_value, req.radius);
            exp_wr <= exp_wr + 1;
         end
         if (rsp.valid && rsp.ready) begin
            results_seen <= results_seen + 1;
            if (exp_wr == exp_rd) begin
               $error("unexpected transaction: stress %h status %0d", rsp.stress, rsp.status);
               errors <= errors + 1;
            end else begin
               e = expected_mem[exp_rd % EXP_DEPTH];
               exp_rd <= exp_rd + 1;
               if (rsp.stress !== e.stress) begin
                  $error("stress: expected %h actual %h", e.stress, rsp.stress);
                  errors <= errors + 1;
               end else if (rsp.status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp.status);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

   assign pending = exp_wr - exp_rd;

endmodule

### tb/von_mises_stress_point_tb.sv
`timescale 1ns / 1ps
module von_mises_stress_point_tb import vms_pkg::*; ;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors, pending, results_seen;
   int   points_sent = 0;
   int   settings_used = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   bit   long_hold_req = 1'b0;
   bit   hold_done;
   int   hold_count = 0;

   vms_req_if req_ch ();
   vms_rsp_if rsp_ch ();
   vms_csr_if csr_ch ();

   always #2 clock = ~clock;

   von_mises_stress_point #(.FRAC_BITS(16)) DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   von_mises_stress_point_checker #(.FRAC_BITS(16)) stress_check (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch),
      .errors(errors), .pending(pending), .results_seen(results_seen)
   );

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.du_dx   = '0;
      req_ch.du_dy   = '0;
      req_ch.dv_dx   = '0;
      req_ch.dv_dy   = '0;
      req_ch.u_value = '0;
      req_ch.radius  = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = REG_LAME_LAMBDA;
      csr_ch.data    = '0;
   end

   // output side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_done    <= 1'b0;
      end else if (long_hold_req && !hold_done && hold_count == 0) begin
         hold_count   <= 400;
         hold_done    <= 1'b1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count   <= hold_count - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic set_material(logic [31:0] lam, logic [31:0] mu, logic [31:0] axi);
      write_reg(REG_LAME_LAMBDA, lam);
      write_reg(REG_SHEAR_MODULUS, mu);
      write_reg(REG_AXISYMMETRIC, axi);
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic send_point(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] d, logic [31:0] u, logic [31:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.du_dx   <= a;
      req_ch.du_dy   <= b;
      req_ch.dv_dx   <= c;
      req_ch.dv_dy   <= d;
      req_ch.u_value <= u;
      req_ch.radius  <= r;
      do @(posedge clock); while (!req_ch.ready);
      points_sent++;
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(5))
         0:       return $urandom;
         1:       return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
         2:       return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
         3: begin
            case ($urandom_range(4))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'hFFFF_FFFF;
               3:       return 32'd1;
               default: return 32'd0;
            endcase
         end
         default: return 32'($signed($urandom_range(1 << 17)) - (1 << 16));
      endcase
   endfunction

   function automatic logic [31:0] rand_radius();
      if ($urandom_range(49) == 0) return 32'd0;
      if ($urandom_range(3) == 0) return rand_field();
      return 32'($urandom_range(32'h0100_0000, 32'h0000_1000));
   endfunction

   task automatic send_random(int count);
      repeat (count) send_point(rand_field(), rand_field(), rand_field(), rand_field(),
                                rand_field(), rand_radius());
   endtask

   task automatic flush();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset material: everything zero
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      flush();
      set_material(32'h0001_0000, 32'h0000_8000, 0);
      send_point(0, 0, 0, 0, 0, 32'h0001_0000);
      send_point(32'h0001_0000, 0, 0, 0, 0, 0);
      send_point(32'hFFFF_0000, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 0, 0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
      send_point(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1);
      flush();
      set_material(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
      send_point(32'd1, 32'd1, 32'd1, 32'd1, 0, 0);
      flush();
      set_material(32'h8000_0000, 32'h0001_0000, 1);
      send_point(32'h0000_1000, 0, 0, 32'h0000_1000, 32'h0001_0000, 0);
      send_point(32'h0000_1000, 0, 0, 32'h0000_1000, 32'h0001_0000, 32'h0002_0000);
      send_point(0, 0, 0, 0, 32'hFFFF_0000, 32'h0002_0000);
      send_point(0, 0, 0, 0, 32'h0001_0000, 32'hFFFE_0000);
      send_point(0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000);
      flush();
      set_material(32'h0000_4000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_point(0, 0, 0, 0, 32'h7FFF_FFFF, 32'd1);
      send_point(0, 0, 0, 0, 32'h8000_0000, 32'd1);
      send_point(32'h10, 32'h20, 32'h30, 32'h40, 32'h50, 32'hFFFF_FFFF);
      flush();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         case (ph)
            0: set_material(32'h0001_8000, 32'h0000_C000, 0);
            1: set_material(32'h8000_0000, 32'h0000_0000, 1);
            2: set_material(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
            3: set_material($urandom, 32'h0000_0000, 0);
            default: set_material(32'($signed($urandom_range(1 << 21)) - (1 << 20)),
                                  $urandom_range(1 << 21), $urandom_range(1));
         endcase
         if (ph == 4) long_hold_req <= 1'b1;
         send_random(200);
         flush();
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (100) @(posedge clock);

      $display("covered %0d points, %0d results, %0d material settings", points_sent,
               results_seen, settings_used);
      $display("with idle, stalled and back-pressured handshakes on both channels");
      if (errors == 0 && pending == 0) begin
         $display("von_mises_stress_point regression: pass");
      end else begin
         $display("von_mises_stress_point regression: fail");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("von_mises_stress_point regression: fail");
      $finish;
   end

endmodule
